// ----- rtl/core/tkfv_pkg.sv -----
// Package for top_k_frequent_values: controller states and the command and
// status groups passed between the controller and the datapath.
// No dependencies.
`default_nettype none

package tkfv_pkg;

    localparam int TOP_COUNT_BITS = 5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_RANK,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_rd;
        logic load_wr;
        logic walk_clr;
        logic walk_rd;
        logic rank_start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic walk_last;
        logic final_seen;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/tkfv_ctrl.sv -----
// Controller of top_k_frequent_values: clearing pass, histogram update,
// ranking walk and result emission sequencing.
// Depends on tkfv_pkg.
`default_nettype none

module tkfv_ctrl
    import tkfv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.walk_clr = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_rd = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.load_wr = 1'b1;
                if (status.final_seen)
                begin
                    cmd.rank_start = 1'b1;
                    state_next     = ST_RANK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RANK:
            begin
                cmd.walk_rd = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/tkfv_dp.sv -----
// Datapath of top_k_frequent_values: histogram memory, ranked list with
// parallel insertion, configuration register and output register.
// Depends on tkfv_pkg.
`default_nettype none

module tkfv_dp
    import tkfv_pkg::*;
#(
    parameter int VALUE_BITS = 8,
    parameter int MAX_K      = 16,
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    output status_t                        status,
    input  wire logic                      cfg_we,
    input  wire logic [TOP_COUNT_BITS-1:0] cfg_data,
    input  wire logic [VALUE_BITS-1:0]     in_value,
    input  wire logic                      in_final,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [VALUE_BITS-1:0]          out_value,
    output logic [COUNT_BITS-1:0]          out_count,
    output logic                           out_end
);

    localparam int NUM_VALUES = 1 << VALUE_BITS;
    localparam int KW         = $clog2(MAX_K + 1);
    localparam int IW         = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    logic [COUNT_BITS-1:0]     hist_mem [NUM_VALUES];
    logic [VALUE_BITS-1:0]     mem_addr;
    logic                      mem_we;
    logic [COUNT_BITS-1:0]     mem_wdata;

    logic [COUNT_BITS-1:0]     rd_data_reg;
    logic [VALUE_BITS-1:0]     rd_addr_reg;
    logic                      pend_reg;
    logic                      final_reg;
    logic [VALUE_BITS-1:0]     walk_addr_reg;
    logic [TOP_COUNT_BITS-1:0] top_count_reg;
    logic [KW-1:0]             eff_k;

    logic [COUNT_BITS-1:0]     rank_cnt_reg  [MAX_K];
    logic [COUNT_BITS-1:0]     rank_cnt_next [MAX_K];
    logic [VALUE_BITS-1:0]     rank_val_reg  [MAX_K];
    logic [VALUE_BITS-1:0]     rank_val_next [MAX_K];
    logic [KW-1:0]             filled_reg;
    logic [KW-1:0]             filled_next;
    logic [IW-1:0]             emit_idx_reg;

    logic [MAX_K-1:0]          gt;
    logic [MAX_K-1:0]          in_k;
    logic                      ins_en;
    logic                      any_gt;
    logic                      emit_last;
    logic                      out_free;

    logic                      out_valid_reg;
    logic [VALUE_BITS-1:0]     out_value_reg;
    logic [COUNT_BITS-1:0]     out_count_reg;
    logic                      out_end_reg;

    // histogram port: read every cycle, written on update and during walks
    always_comb
    begin
        if (cmd.load_rd)
        begin
            mem_addr = in_value;
        end
        else if (cmd.load_wr)
        begin
            mem_addr = rd_addr_reg;
        end
        else
        begin
            mem_addr = walk_addr_reg;
        end
        mem_we = cmd.load_wr | cmd.walk_clr | cmd.walk_rd;
        if (cmd.load_wr)
        begin
            mem_wdata = (&rd_data_reg) ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);
        end
        else
        begin
            mem_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= hist_mem[mem_addr];
        rd_addr_reg <= mem_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            final_reg     <= 1'b0;
            walk_addr_reg <= '0;
            top_count_reg <= TOP_COUNT_BITS'(1);
        end
        else
        begin
            pend_reg <= cmd.walk_rd;
            if (cmd.load_rd)
            begin
                final_reg <= in_final;
            end
            if (cmd.walk_clr || cmd.walk_rd)
            begin
                walk_addr_reg <= walk_addr_reg + VALUE_BITS'(1);
            end
            if (cfg_we)
            begin
                top_count_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (top_count_reg == '0)
        begin
            eff_k = KW'(1);
        end
        else if (int'(top_count_reg) > MAX_K)
        begin
            eff_k = KW'(MAX_K);
        end
        else
        begin
            eff_k = KW'(top_count_reg);
        end
    end

    // insert the count just read ahead of every entry it ties or beats;
    // equal counts fall behind because values are walked in rising order
    always_comb
    begin
        ins_en = pend_reg && (rd_data_reg != '0);
        for (int i = 0; i < MAX_K; i++)
        begin
            gt[i]   = (KW'(i) >= filled_reg) || (rd_data_reg >= rank_cnt_reg[i]);
            in_k[i] = KW'(i) < eff_k;
        end
        any_gt = |(gt & in_k);
        for (int i = 0; i < MAX_K; i++)
        begin
            rank_cnt_next[i] = rank_cnt_reg[i];
            rank_val_next[i] = rank_val_reg[i];
            if (ins_en && in_k[i] && gt[i])
            begin
                if (i == 0)
                begin
                    rank_cnt_next[i] = rd_data_reg;
                    rank_val_next[i] = rd_addr_reg;
                end
                else if (!gt[i-1])
                begin
                    rank_cnt_next[i] = rd_data_reg;
                    rank_val_next[i] = rd_addr_reg;
                end
                else
                begin
                    rank_cnt_next[i] = rank_cnt_reg[i-1];
                    rank_val_next[i] = rank_val_reg[i-1];
                end
            end
        end
        if (cmd.rank_start)
        begin
            filled_next = '0;
        end
        else if (ins_en && any_gt && (filled_reg < eff_k))
        begin
            filled_next = filled_reg + KW'(1);
        end
        else
        begin
            filled_next = filled_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            rank_cnt_reg[i] <= rank_cnt_next[i];
            rank_val_reg[i] <= rank_val_next[i];
        end
    end

    assign emit_last = (KW'(emit_idx_reg) + KW'(1)) == filled_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
            if (cmd.rank_start)
            begin
                emit_idx_reg <= '0;
            end
            else if (cmd.emit)
            begin
                emit_idx_reg <= emit_idx_reg + IW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_value_reg <= rank_val_reg[emit_idx_reg];
            out_count_reg <= rank_cnt_reg[emit_idx_reg];
            out_end_reg   <= emit_last;
        end
    end

    assign status.walk_last  = &walk_addr_reg;
    assign status.final_seen = final_reg;
    assign status.emit_last  = emit_last;
    assign status.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_count = out_count_reg;
    assign out_end   = out_end_reg;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");
    a_update_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_wr |-> $past(cmd.load_rd))
        else $error("histogram write without a preceding read");
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (filled_reg != '0))
        else $error("emission from an empty ranked list");
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= KW'(MAX_K))
        else $error("ranked list fill count out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/top_k_frequent_values.sv -----
// Top level of top_k_frequent_values: joins the controller and the datapath
// and provides the configuration write port.
// Depends on tkfv_pkg, tkfv_ctrl and tkfv_dp.
`default_nettype none

// After reset the block sweeps its histogram memory to zero and takes no
// request until that is done (top_count writes are taken at any time). Each
// value then takes one histogram read and one saturating write back through
// the single memory port. On the request that carries final_item the block
// walks the whole histogram with one read per entry, clearing it as it goes
// and sorting each nonzero count into a list of up to MAX_K entries. It then
// delivers up to top_count results, one per cycle while out_ready is high,
// largest count first and the larger value first among equal counts; run_end
// marks the last. A top_count of zero acts as one and values above MAX_K act
// as MAX_K.

module top_k_frequent_values
    import tkfv_pkg::*;
#(
    parameter int VALUE_BITS = 8,
    parameter int MAX_K      = 16,
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [TOP_COUNT_BITS-1:0] top_count,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [VALUE_BITS-1:0]     value,
    input  wire logic                      final_item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [VALUE_BITS-1:0]          frequent_value,
    output logic [COUNT_BITS-1:0]          occurrences,
    output logic                           run_end
);

    cmd_t    cmd;
    status_t status;
    logic    cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    tkfv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tkfv_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_K      (MAX_K),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_data  (top_count),
        .in_value  (value),
        .in_final  (final_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_value (frequent_value),
        .out_count (occurrences),
        .out_end   (run_end)
    );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for top_k_frequent_values: streams value requests,
// predicts the ranked top-k results per set and compares them on the output.
// Depends on tkfv_pkg and the top_k_frequent_values RTL.
`timescale 1ns / 100ps

module testbench;
    import tkfv_pkg::*;

    localparam int VALUE_BITS  = 8;
    localparam int COUNT_BITS  = 16;
    localparam int MAX_K       = 16;
    localparam int NUM_VALUES  = 1 << VALUE_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 300;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  final_item;
    } value_req_t;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
        logic                  run_end;
    } rank_entry_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [TOP_COUNT_BITS-1:0] top_count = 5'd1;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [VALUE_BITS-1:0]     value = '0;
    logic                      final_item = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [VALUE_BITS-1:0]     frequent_value;
    logic [COUNT_BITS-1:0]     occurrences;
    logic                      run_end;

    value_req_t                value_stream [$];
    rank_entry_t               expected_ranking [$];
    value_req_t                current_req;
    logic                      in_fire;

    logic [COUNT_BITS-1:0]     value_histogram [0:NUM_VALUES-1] = '{default: '0};
    logic [TOP_COUNT_BITS-1:0] rank_limit = 5'd1;

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned requests_taken    = 0;
    int unsigned sets_ranked       = 0;
    int unsigned results_checked   = 0;
    int unsigned mismatches        = 0;
    int unsigned cycle_count       = 0;

    top_k_frequent_values #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_K      (MAX_K),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .top_count      (top_count),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .final_item     (final_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frequent_value (frequent_value),
        .occurrences    (occurrences),
        .run_end        (run_end)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Count one value; on the last of a set, rank the histogram and clear it.
    function automatic void count_value(input value_req_t req);
        bit taken [0:NUM_VALUES-1];
        int best;
        int limit;
        rank_entry_t entry;
        if (value_histogram[req.value] != COUNT_MAX)
            value_histogram[req.value]++;
        if (!req.final_item)
            return;
        limit = (rank_limit == 0) ? 1 : (rank_limit > MAX_K) ? MAX_K : int'(rank_limit);
        taken = '{default: 1'b0};
        for (int r = 0; r < limit; r++)
        begin
            best = -1;
            for (int v = 0; v < NUM_VALUES; v++)
            begin
                if (value_histogram[v] != 0 && !taken[v] &&
                    (best < 0 || value_histogram[v] >= value_histogram[best]))
                    best = v;
            end
            if (best < 0)
                break;
            taken[best]   = 1'b1;
            entry.value   = VALUE_BITS'(best);
            entry.count   = value_histogram[best];
            entry.run_end = 1'b0;
            expected_ranking.insert(expected_ranking.size(), entry);
        end
        expected_ranking[expected_ranking.size()-1].run_end = 1'b1;
        value_histogram = '{default: '0};
        sets_ranked++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
            in_fire <= in_valid && in_ready;
    end

    // Driver: retire the accepted request, then present the next one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                count_value(current_req);
                requests_taken++;
            end
            if (!in_valid || in_fire)
            begin
                if (value_stream.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    current_req = value_stream.pop_front();
                    value       = current_req.value;
                    final_item  = current_req.final_item;
                    in_valid    = 1'b1;
                end
                else
                begin
                    in_valid = 1'b0;
                end
            end
            out_ready = ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        rank_entry_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_ranking.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d count %0d run_end %0b",
                             frequent_value, occurrences, run_end);
            end
            else
            begin
                want = expected_ranking.pop_front();
                results_checked++;
                if (frequent_value !== want.value || occurrences !== want.count ||
                    run_end !== want.run_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected value %0d count %0d run_end %0b,",
                                  " got value %0d count %0d run_end %0b"},
                                 want.value, want.count, want.run_end,
                                 frequent_value, occurrences, run_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** top_k_frequent_values: FAILED **");
            $finish;
        end
    end

    task automatic queue_value(input logic [VALUE_BITS-1:0] v, input logic last);
        value_req_t req;
        req.value      = v;
        req.final_item = last;
        value_stream.insert(value_stream.size(), req);
    endtask

    task automatic write_top_count(input logic [TOP_COUNT_BITS-1:0] k);
        @(negedge clk);
        cfg_valid = 1'b1;
        top_count = k;
        do
            @(posedge clk);
        while (!cfg_ready);
        rank_limit = k;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold until every request is taken and every result has come back.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (value_stream.size() != 0 || in_valid || expected_ranking.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_random_set();
        logic [VALUE_BITS-1:0] pool [0:3];
        int n;
        n = $urandom_range(1, 9);
        foreach (pool[i])
            pool[i] = VALUE_BITS'($urandom_range(0, NUM_VALUES - 1));
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(1))
                queue_value(pool[$urandom_range(0, 3)], i == n - 1);
            else
                queue_value(VALUE_BITS'($urandom_range(0, NUM_VALUES - 1)), i == n - 1);
        end
    endtask

    task automatic run_random_groups(input logic [TOP_COUNT_BITS-1:0] first_k);
        for (int g = 0; g < 2; g++)
        begin
            write_top_count(g == 0 ? first_k : TOP_COUNT_BITS'($urandom_range(0, 31)));
            repeat ($urandom_range(3, 4)) queue_random_set();
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct   = 8;
        receiver_idle_pct = 51;

        queue_value(8'd0, 1'b0);
        queue_value(8'd255, 1'b0);
        queue_value(8'd255, 1'b1);
        wait_drained();

        write_top_count(5'd0);
        queue_value(8'h33, 1'b0);
        queue_value(8'h33, 1'b0);
        queue_value(8'hCC, 1'b1);
        wait_drained();

        write_top_count(5'd16);
        queue_value(8'h80, 1'b1);
        wait_drained();

        // drop the two lowest of seventeen singletons past the k limit
        write_top_count(5'd31);
        queue_value(8'hAA, 1'b0);
        queue_value(8'hAA, 1'b0);
        queue_value(8'd0, 1'b0);
        queue_value(8'd255, 1'b0);
        for (int v = 1; v <= 15; v++)
            queue_value(8'(v), v == 15);
        wait_drained();

        run_random_groups(5'd16);

        sender_idle_pct   = 51;
        receiver_idle_pct = 8;
        run_random_groups(5'd1);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_groups(5'd31);

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d value requests in %0d sets, %0d ranked results checked,",
                 requests_taken, sets_ranked, results_checked);
        $display("top_count from 0 to 31, ties, short sets and sets past the k limit");
        if (mismatches == 0)
        begin
            $display("** top_k_frequent_values: PASSED **");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("** top_k_frequent_values: FAILED **");
        end
        $finish;
    end

endmodule
